FILE: hw/rtl/jsu_pkg.sv
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
// Used by every module of the block but the checker; depends on nothing.
package jsu_pkg;

  localparam int HOLD_DEPTH = 8;
  localparam int HOLD_CW = $clog2(HOLD_DEPTH + 1);
  localparam int HOLD_IW = $clog2(HOLD_DEPTH);
  localparam int CP_W = 21;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_ESC = 3'd1;
  localparam logic [2:0] MODE_HEX = 3'd2;
  localparam logic [2:0] MODE_PAIR_BS = 3'd3;
  localparam logic [2:0] MODE_PAIR_U = 3'd4;
  localparam logic [2:0] MODE_PAIR_HEX = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_BS_CTRL = 8'h08;
  localparam logic [7:0] CH_FF_CTRL = 8'h0C;
  localparam logic [7:0] CH_LF_CTRL = 8'h0A;
  localparam logic [7:0] CH_CR_CTRL = 8'h0D;
  localparam logic [7:0] CH_TAB_CTRL = 8'h09;

  localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LOW_SUR_MAX = 16'hDFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] TWO_BYTE_MIN = 21'h80;
  localparam logic [CP_W-1:0] THREE_BYTE_MIN = 21'h800;

  // One held byte of an escape, with the end-of-string mark it arrived with.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } hbyte_t;

  // One output command: a raw byte, or a code point to be encoded as UTF-8.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            raw;
    logic            last;
  } cmd_t;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b inside {[8'h30:8'h39]}) v = 5'(b - 8'h30);
    else if (b inside {[8'h61:8'h66]}) v = 5'(b - 8'h57);
    else if (b inside {[8'h41:8'h46]}) v = 5'(b - 8'h37);
    return v;
  endfunction

  function automatic logic [2:0] utf8_len(input cmd_t c);
    logic [2:0] n;
    if (c.raw || c.cp < TWO_BYTE_MIN) n = 3'd1;
    else if (c.cp < THREE_BYTE_MIN) n = 3'd2;
    else if (c.cp < SUPP_BASE) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input cmd_t c, input logic [1:0] idx);
    logic [2:0] n;
    logic [7:0] r;
    n = utf8_len(c);
    r = c.cp[7:0];
    case (n)
      3'd2: r = (idx == 2'd0) ? {3'b110, c.cp[10:6]} : {2'b10, c.cp[5:0]};
      3'd3: begin
        case (idx)
          2'd0: r = {4'b1110, c.cp[15:12]};
          2'd1: r = {2'b10, c.cp[11:6]};
          default: r = {2'b10, c.cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0: r = {5'b11110, c.cp[20:18]};
          2'd1: r = {2'b10, c.cp[17:12]};
          2'd2: r = {2'b10, c.cp[11:6]};
          default: r = {2'b10, c.cp[5:0]};
        endcase
      end
      default: r = c.cp[7:0];
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/jsu_front.sv
// Escape decoder: takes raw words and held replay bytes, one a cycle while the
// command queue is not full, and issues output commands. Depends on jsu_pkg.
module jsu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           cmd_full,
  output logic           cmd_wr,
  output jsu_pkg::cmd_t  cmd
);

  logic [2:0] mode, mode_next;
  logic [1:0] hex_count, hex_count_next;
  logic [15:0] high_code, high_code_next;
  logic [15:0] low_code, low_code_next;
  jsu_pkg::hbyte_t hold [jsu_pkg::HOLD_DEPTH];
  jsu_pkg::hbyte_t hold_next [jsu_pkg::HOLD_DEPTH];
  logic [jsu_pkg::HOLD_CW-1:0] hold_cnt, hold_cnt_next;
  jsu_pkg::hbyte_t rq [jsu_pkg::HOLD_DEPTH];
  jsu_pkg::hbyte_t rq_next [jsu_pkg::HOLD_DEPTH];
  logic [jsu_pkg::HOLD_CW-1:0] rq_cnt, rq_cnt_next;

  logic from_rq, step;
  logic [7:0] b;
  logic l;
  logic [4:0] hv;
  logic bad_hex;
  logic do_hold, clr_hold, do_replay, emit;
  jsu_pkg::cmd_t ecmd;
  logic [15:0] code_shift;
  jsu_pkg::hbyte_t popped [jsu_pkg::HOLD_DEPTH];
  logic [jsu_pkg::HOLD_CW-1:0] ext_cnt, rest_cnt;
  logic [jsu_pkg::HOLD_CW-1:0] ri;

  assign from_rq = (rq_cnt != '0);
  assign full = from_rq || cmd_full;
  assign step = !cmd_full && (from_rq || push);
  assign b = from_rq ? rq[0].data : in_byte;
  assign l = from_rq ? rq[0].last : in_last;
  assign hv = jsu_pkg::hex_value(b);
  assign bad_hex = hv[4] || (l && hex_count != 2'd3);

  always_comb begin
    mode_next = mode;
    hex_count_next = hex_count;
    high_code_next = high_code;
    low_code_next = low_code;
    do_hold = 1'b0;
    clr_hold = 1'b0;
    do_replay = 1'b0;
    emit = 1'b0;
    ecmd = '{cp: {13'd0, b}, raw: 1'b1, last: 1'b0};
    code_shift = '0;
    case (mode)
      jsu_pkg::MODE_ESC: begin
        mode_next = jsu_pkg::MODE_IDLE;
        emit = 1'b1;
        case (b)
          jsu_pkg::CH_B: ecmd.cp = {13'd0, jsu_pkg::CH_BS_CTRL};
          jsu_pkg::CH_F: ecmd.cp = {13'd0, jsu_pkg::CH_FF_CTRL};
          jsu_pkg::CH_N: ecmd.cp = {13'd0, jsu_pkg::CH_LF_CTRL};
          jsu_pkg::CH_R: ecmd.cp = {13'd0, jsu_pkg::CH_CR_CTRL};
          jsu_pkg::CH_T: ecmd.cp = {13'd0, jsu_pkg::CH_TAB_CTRL};
          jsu_pkg::CH_U: begin
            if (!l) begin
              emit = 1'b0;
              mode_next = jsu_pkg::MODE_HEX;
              hex_count_next = '0;
              high_code_next = '0;
              clr_hold = 1'b1;
            end
          end
          default: ecmd.cp = {13'd0, b};
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        do_hold = 1'b1;
        if (bad_hex) begin
          emit = 1'b1;
          ecmd.cp = {13'd0, jsu_pkg::CH_U};
          do_replay = 1'b1;
        end else begin
          code_shift = {high_code[11:0], hv[3:0]};
          high_code_next = code_shift;
          hex_count_next = hex_count + 2'd1;
          if (hex_count == 2'd3) begin
            clr_hold = 1'b1;
            if (code_shift >= jsu_pkg::HIGH_SUR_MIN && code_shift <= jsu_pkg::HIGH_SUR_MAX
                && !l) begin
              mode_next = jsu_pkg::MODE_PAIR_BS;
            end else begin
              mode_next = jsu_pkg::MODE_IDLE;
              emit = 1'b1;
              ecmd = '{cp: {5'd0, code_shift}, raw: 1'b0, last: 1'b0};
            end
          end
        end
      end
      jsu_pkg::MODE_PAIR_BS, jsu_pkg::MODE_PAIR_U: begin
        do_hold = 1'b1;
        if (mode == jsu_pkg::MODE_PAIR_BS && b == jsu_pkg::CH_BSLASH && !l) begin
          mode_next = jsu_pkg::MODE_PAIR_U;
        end else if (mode == jsu_pkg::MODE_PAIR_U && b == jsu_pkg::CH_U && !l) begin
          mode_next = jsu_pkg::MODE_PAIR_HEX;
          hex_count_next = '0;
          low_code_next = '0;
        end else begin
          emit = 1'b1;
          ecmd = '{cp: {5'd0, high_code}, raw: 1'b0, last: 1'b0};
          do_replay = 1'b1;
        end
      end
      jsu_pkg::MODE_PAIR_HEX: begin
        code_shift = {low_code[11:0], hv[3:0]};
        if (bad_hex) begin
          do_hold = 1'b1;
          emit = 1'b1;
          ecmd = '{cp: {5'd0, high_code}, raw: 1'b0, last: 1'b0};
          do_replay = 1'b1;
        end else begin
          low_code_next = code_shift;
          hex_count_next = hex_count + 2'd1;
          do_hold = 1'b1;
          if (hex_count == 2'd3) begin
            if (code_shift >= jsu_pkg::LOW_SUR_MIN && code_shift <= jsu_pkg::LOW_SUR_MAX) begin
              do_hold = 1'b0;
              clr_hold = 1'b1;
              mode_next = jsu_pkg::MODE_IDLE;
              emit = 1'b1;
              ecmd = '{cp: jsu_pkg::SUPP_BASE + {1'b0, high_code[9:0], code_shift[9:0]},
                       raw: 1'b0, last: 1'b0};
            end else begin
              emit = 1'b1;
              ecmd = '{cp: {5'd0, high_code}, raw: 1'b0, last: 1'b0};
              do_replay = 1'b1;
            end
          end
        end
      end
      default: begin
        mode_next = jsu_pkg::MODE_IDLE;
        if (b == jsu_pkg::CH_BSLASH && !l) mode_next = jsu_pkg::MODE_ESC;
        else emit = 1'b1;
      end
    endcase

    // Held bytes, with the current word appended where it is held.
    for (int i = 0; i < jsu_pkg::HOLD_DEPTH; i++) hold_next[i] = hold[i];
    ext_cnt = hold_cnt;
    if (do_hold && hold_cnt < jsu_pkg::HOLD_CW'(jsu_pkg::HOLD_DEPTH)) begin
      hold_next[hold_cnt[jsu_pkg::HOLD_IW-1:0]] = '{last: l, data: b};
      ext_cnt = hold_cnt + jsu_pkg::HOLD_CW'(1);
    end

    for (int i = 0; i < jsu_pkg::HOLD_DEPTH - 1; i++) popped[i] = rq[i + 1];
    popped[jsu_pkg::HOLD_DEPTH - 1] = rq[jsu_pkg::HOLD_DEPTH - 1];
    rest_cnt = from_rq ? rq_cnt - jsu_pkg::HOLD_CW'(1) : rq_cnt;

    ecmd.last = l && !do_replay;
    hold_cnt_next = clr_hold ? '0 : ext_cnt;
    rq_cnt_next = rest_cnt;
    ri = '0;
    for (int i = 0; i < jsu_pkg::HOLD_DEPTH; i++) rq_next[i] = popped[i];
    if (do_replay) begin
      // The held bytes go back in front of whatever was still waiting.
      for (int i = 0; i < jsu_pkg::HOLD_DEPTH; i++) begin
        ri = jsu_pkg::HOLD_CW'(i) - ext_cnt;
        if (jsu_pkg::HOLD_CW'(i) < ext_cnt) rq_next[i] = hold_next[i];
        else rq_next[i] = popped[ri[jsu_pkg::HOLD_IW-1:0]];
      end
      rq_cnt_next = ext_cnt + rest_cnt;
      mode_next = jsu_pkg::MODE_IDLE;
      hex_count_next = '0;
      hold_cnt_next = '0;
    end else if (l) begin
      mode_next = jsu_pkg::MODE_IDLE;
      hex_count_next = '0;
      high_code_next = '0;
      low_code_next = '0;
      hold_cnt_next = '0;
    end
  end

  assign cmd_wr = step && emit;
  assign cmd = ecmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jsu_pkg::MODE_IDLE;
      hex_count <= '0;
      high_code <= '0;
      low_code <= '0;
      hold_cnt <= '0;
      rq_cnt <= '0;
    end else if (step) begin
      mode <= mode_next;
      hex_count <= hex_count_next;
      high_code <= high_code_next;
      low_code <= low_code_next;
      hold_cnt <= hold_cnt_next;
      rq_cnt <= rq_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < jsu_pkg::HOLD_DEPTH; i++) begin
        hold[i] <= hold_next[i];
        rq[i] <= rq_next[i];
      end
    end
  end

endmodule

FILE: hw/rtl/jsu_cmd_fifo.sv
// Two-entry command queue between the escape decoder and the UTF-8 encoder.
// Depends on jsu_pkg.
module jsu_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  jsu_pkg::cmd_t  wr_cmd,
  output logic           fifo_full,
  input  logic           rd,
  output logic           fifo_empty,
  output jsu_pkg::cmd_t  rd_cmd
);

  jsu_pkg::cmd_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;

  assign fifo_full = (count == 2'd2);
  assign fifo_empty = (count == 2'd0);
  assign rd_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot[wr_ptr] <= wr_cmd;
  end

endmodule

FILE: hw/rtl/jsu_back.sv
// UTF-8 encoder: splits each command into its bytes and holds one output word.
// Depends on jsu_pkg.
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           fifo_empty,
  input  jsu_pkg::cmd_t  head,
  output logic           rd,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic [1:0] idx;
  logic valid;
  logic load, final_byte;
  logic [2:0] len;

  assign len = jsu_pkg::utf8_len(head);
  assign final_byte = ({1'b0, idx} + 3'd1 == len);
  assign load = !fifo_empty && (!valid || pop);
  assign rd = load && final_byte;
  assign empty = !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= jsu_pkg::utf8_byte(head, idx);
      out_last <= head.last && final_byte;
    end
  end

endmodule

FILE: hw/rtl/json_string_unescape_utf8_top.sv
// JSON string unescaper: raw string words in, unescaped UTF-8 words out.
// Throughput: one input word a cycle when it yields one output byte and the output
// is popped; a code point is sent one UTF-8 byte at a time, and a failed escape
// replays its held bytes at one a cycle. Synchronous active-high reset empties both queues.
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic cmd_wr, cmd_rd, cmd_full, cmd_empty;
  jsu_pkg::cmd_t wr_cmd, head;

  jsu_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .in_last(in_last), .cmd_full(cmd_full), .cmd_wr(cmd_wr), .cmd(wr_cmd)
  );

  jsu_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(cmd_wr), .wr_cmd(wr_cmd), .fifo_full(cmd_full),
    .rd(cmd_rd), .fifo_empty(cmd_empty), .rd_cmd(head)
  );

  jsu_back u_back (
    .clk(clk), .rst(rst), .fifo_empty(cmd_empty), .head(head), .rd(cmd_rd),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_last(out_last)
  );

endmodule

FILE: hw/rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends only on the top level's ports.
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Nothing is waiting to be read straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // With both queues cleared the block takes a word at once.
  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // A word that is not taken stays on the ports unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("output word changed while stalled");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .out_byte(out_byte), .out_last(out_last)
);
